// ===== sv/bbn_pkg.sv =====
// ----------------------------------------------------------------------------
// bbn_pkg
// shared types and constants of the bounding box normalizer
// ----------------------------------------------------------------------------
package bbn_pkg;

  localparam int SPAN_BITS  = 23;
  localparam int SCALE_BITS = 32;
  localparam int SCALE_FRAC = 16;
  localparam int NUM_BITS   = SPAN_BITS + SCALE_FRAC;
  localparam int AXES       = 3;

  localparam logic [SPAN_BITS-1:0] SPAN_RESET = 23'd163840;

  typedef struct packed {
    logic       take;
    logic       start;
    logic       ext_en;
    logic       sq_en;
    logic [1:0] sq_sel;
    logic       acc_en;
    logic       rt_en;
    logic       dv_en;
    logic       out_load;
  } bbn_cmd_t;

  typedef struct packed {
    logic diag_zero;
  } bbn_sts_t;

endpackage

// ===== sv/bbn_if.sv =====
// ----------------------------------------------------------------------------
// bbn interfaces
// vertex and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface bbn_vertex_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic signed [COORD_BITS-1:0] vertex_z;
  logic                         last_vertex;

  modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

interface bbn_result_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] low_x;
  logic signed [COORD_BITS-1:0] low_y;
  logic signed [COORD_BITS-1:0] low_z;
  logic signed [COORD_BITS-1:0] high_x;
  logic signed [COORD_BITS-1:0] high_y;
  logic signed [COORD_BITS-1:0] high_z;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic signed [COORD_BITS-1:0] center_z;
  logic        [COORD_BITS:0]   diagonal;
  logic        [31:0]           scale_factor;
  logic                         degenerate;

  modport source (output valid, low_x, low_y, low_z, high_x, high_y, high_z,
                  center_x, center_y, center_z, diagonal, scale_factor, degenerate,
                  input ready);
  modport sink   (input valid, low_x, low_y, low_z, high_x, high_y, high_z,
                  center_x, center_y, center_z, diagonal, scale_factor, degenerate,
                  output ready);
endinterface

// ===== sv/bbn_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbn_ctrl
// sequencer for box capture, squaring, square root, division and output
// ----------------------------------------------------------------------------
module bbn_ctrl #(
  parameter int COORD_BITS = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bbn_pkg::bbn_sts_t sts,
  output bbn_pkg::bbn_cmd_t cmd
);
  import bbn_pkg::*;

  localparam int ROOT_W = COORD_BITS + 1;
  localparam int STEPS  = (NUM_BITS > ROOT_W) ? NUM_BITS : ROOT_W;
  localparam int CNT_W  = $clog2(STEPS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXT  = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_ROOT = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    out_valid_next = out_valid & ~out_ready;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid && in_last) begin
          cmd.start  = 1'b1;
          state_next = S_EXT;
        end
      end
      S_EXT: begin
        cmd.ext_en = 1'b1;
        cnt_next   = '0;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.sq_en  = (cnt < CNT_W'(AXES));
        cmd.sq_sel = cnt[1:0];
        cmd.acc_en = (cnt != '0);
        cnt_next   = cnt + 1'b1;
        if (cnt == CNT_W'(AXES)) begin
          cnt_next   = '0;
          state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        cmd.rt_en = 1'b1;
        cnt_next  = cnt + 1'b1;
        if (cnt == CNT_W'(ROOT_W - 1)) begin
          cnt_next   = '0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.diag_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.dv_en = 1'b1;
          cnt_next  = cnt + 1'b1;
          if (cnt == CNT_W'(NUM_BITS - 1)) begin
            cnt_next   = '0;
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== sv/bbn_datapath.sv =====
// ----------------------------------------------------------------------------
// bbn_datapath
// running box, extents, sum of squares, bit-serial root and divider
// ----------------------------------------------------------------------------
module bbn_datapath #(
  parameter int COORD_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [bbn_pkg::SPAN_BITS-1:0]       cfg_write_data,
  input  logic signed [COORD_BITS-1:0]        vertex_x,
  input  logic signed [COORD_BITS-1:0]        vertex_y,
  input  logic signed [COORD_BITS-1:0]        vertex_z,
  input  bbn_pkg::bbn_cmd_t                   cmd,
  output bbn_pkg::bbn_sts_t                   sts,
  output logic signed [COORD_BITS-1:0]        low_x,
  output logic signed [COORD_BITS-1:0]        low_y,
  output logic signed [COORD_BITS-1:0]        low_z,
  output logic signed [COORD_BITS-1:0]        high_x,
  output logic signed [COORD_BITS-1:0]        high_y,
  output logic signed [COORD_BITS-1:0]        high_z,
  output logic signed [COORD_BITS-1:0]        center_x,
  output logic signed [COORD_BITS-1:0]        center_y,
  output logic signed [COORD_BITS-1:0]        center_z,
  output logic [COORD_BITS:0]                 diagonal,
  output logic [bbn_pkg::SCALE_BITS-1:0]      scale_factor,
  output logic                                degenerate
);
  import bbn_pkg::*;

  localparam int ROOT_W = COORD_BITS + 1;
  localparam int SUM_W  = 2 * ROOT_W;
  localparam int PROD_W = 2 * COORD_BITS;
  localparam int REM_W  = ROOT_W + 1;

  localparam logic signed [COORD_BITS-1:0] MAXV = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] MINV = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic [SPAN_BITS-1:0] span;

  logic signed [COORD_BITS-1:0] vtx      [AXES];
  logic signed [COORD_BITS-1:0] run_min  [AXES];
  logic signed [COORD_BITS-1:0] run_max  [AXES];
  logic signed [COORD_BITS-1:0] min_next [AXES];
  logic signed [COORD_BITS-1:0] max_next [AXES];
  logic signed [COORD_BITS-1:0] box_lo   [AXES];
  logic signed [COORD_BITS-1:0] box_hi   [AXES];
  logic        [COORD_BITS-1:0] ext      [AXES];
  logic signed [COORD_BITS:0]   mid_sum  [AXES];

  logic [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]    acc;
  logic [ROOT_W-1:0]   root;
  logic [REM_W-1:0]    rem;
  logic [REM_W+1:0]    rem_sh;
  logic [REM_W+1:0]    trial;
  logic [NUM_BITS-1:0] dvd;
  logic [ROOT_W-1:0]   drem;
  logic [ROOT_W:0]     dv_sh;
  logic                overflow;

  assign vtx[0] = vertex_x;
  assign vtx[1] = vertex_y;
  assign vtx[2] = vertex_z;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      min_next[a] = (vtx[a] < run_min[a]) ? vtx[a] : run_min[a];
      max_next[a] = (vtx[a] > run_max[a]) ? vtx[a] : run_max[a];
      mid_sum[a]  = {box_lo[a][COORD_BITS-1], box_lo[a]} + {box_hi[a][COORD_BITS-1], box_hi[a]};
    end
  end

  assign rem_sh   = {rem, acc[SUM_W-1 -: 2]};
  assign trial    = {1'b0, root, 2'b01};
  assign dv_sh    = {drem, dvd[NUM_BITS-1]};
  assign overflow = |dvd[NUM_BITS-1:SCALE_BITS];
  assign sts.diag_zero = (root == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      span <= SPAN_RESET;
    end else if (cfg_write_en) begin
      span <= cfg_write_data;
    end
  end

  // running extremes, reset after the last vertex of a model
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXES; a++) begin
        run_min[a] <= MAXV;
        run_max[a] <= MINV;
      end
    end else if (cmd.take) begin
      for (int a = 0; a < AXES; a++) begin
        run_min[a] <= cmd.start ? MAXV : min_next[a];
        run_max[a] <= cmd.start ? MINV : max_next[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int a = 0; a < AXES; a++) begin
        box_lo[a] <= min_next[a];
        box_hi[a] <= max_next[a];
      end
      acc  <= '0;
      root <= '0;
      rem  <= '0;
      drem <= '0;
      dvd  <= {span, {SCALE_FRAC{1'b0}}};
    end
    if (cmd.ext_en) begin
      for (int a = 0; a < AXES; a++) begin
        ext[a] <= box_hi[a] - box_lo[a];
      end
    end
    if (cmd.sq_en) begin
      prod <= ext[cmd.sq_sel] * ext[cmd.sq_sel];
    end
    if (cmd.acc_en) begin
      acc <= acc + SUM_W'(prod);
    end
    // one root bit per cycle
    if (cmd.rt_en) begin
      acc <= {acc[SUM_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= REM_W'(rem_sh - trial);
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[REM_W-1:0];
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
    // restoring division, quotient shifts into the dividend register
    if (cmd.dv_en) begin
      if (dv_sh >= {1'b0, root}) begin
        drem <= ROOT_W'(dv_sh - {1'b0, root});
        dvd  <= {dvd[NUM_BITS-2:0], 1'b1};
      end else begin
        drem <= dv_sh[ROOT_W-1:0];
        dvd  <= {dvd[NUM_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      low_x    <= box_lo[0];
      low_y    <= box_lo[1];
      low_z    <= box_lo[2];
      high_x   <= box_hi[0];
      high_y   <= box_hi[1];
      high_z   <= box_hi[2];
      center_x <= mid_sum[0][COORD_BITS:1];
      center_y <= mid_sum[1][COORD_BITS:1];
      center_z <= mid_sum[2][COORD_BITS:1];
      diagonal <= root;
      if (sts.diag_zero || overflow) begin
        scale_factor <= '1;
        degenerate   <= 1'b1;
      end else begin
        scale_factor <= dvd[SCALE_BITS-1:0];
        degenerate   <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/bounding_box_normalizer.sv =====
// ----------------------------------------------------------------------------
// bounding_box_normalizer
// axis-aligned bounding box, centroid, diagonal and uniform scale of a model
// ----------------------------------------------------------------------------
// vertices without the last mark transfer one per cycle while idle
// after the last vertex the extents and their sum of squares are formed,
// then the bit-serial square root and divider run (one bit a cycle)
// a zero diagonal skips the divider; the result sits in an output register
// rst is synchronous: box returns to its extremes, span to 2.5
module bounding_box_normalizer #(
  parameter int COORD_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [bbn_pkg::SPAN_BITS-1:0] cfg_write_data,
  bbn_vertex_if.sink                    vertex,
  bbn_result_if.source                  result
);
  import bbn_pkg::*;

  bbn_cmd_t cmd;
  bbn_sts_t sts;

  bbn_ctrl #(
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vertex.valid),
    .in_last   (vertex.last_vertex),
    .in_ready  (vertex.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bbn_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .vertex_x       (vertex.vertex_x),
    .vertex_y       (vertex.vertex_y),
    .vertex_z       (vertex.vertex_z),
    .cmd            (cmd),
    .sts            (sts),
    .low_x          (result.low_x),
    .low_y          (result.low_y),
    .low_z          (result.low_z),
    .high_x         (result.high_x),
    .high_y         (result.high_y),
    .high_z         (result.high_z),
    .center_x       (result.center_x),
    .center_y       (result.center_y),
    .center_z       (result.center_z),
    .diagonal       (result.diagonal),
    .scale_factor   (result.scale_factor),
    .degenerate     (result.degenerate)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// testbench of the bounding box normalizer: a directed table of vertices, then
// random models under several span settings; every result transfer is checked
// field by field against typed-in results or a predictor of accepted vertices
// ----------------------------------------------------------------------------
module tb_top;
  import bbn_pkg::*;

  localparam int COORD_BITS  = 24;
  localparam int DIAG_BITS   = COORD_BITS + 1;
  localparam int C_MAX       = 2 ** (COORD_BITS - 1) - 1;
  localparam int C_MIN       = -(2 ** (COORD_BITS - 1));
  localparam int BUSY_CYCLES = 100;
  localparam int HOLD_CYCLES = 600;
  localparam int PHASE_ITEMS = 325;
  localparam int PHASE_COUNT = 6;

  typedef longint unsigned u64_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam coord_t COORD_MAX = coord_t'(C_MAX);
  localparam coord_t COORD_MIN = coord_t'(C_MIN);
  localparam logic [SCALE_BITS-1:0] SCALE_SAT = '1;
  localparam logic [SPAN_BITS-1:0]  SPAN_MAX  = '1;

  typedef enum {SPREAD_FULL, SPREAD_TIGHT, SPREAD_EXTREME, SPREAD_POINT} spread_t;

  typedef struct {
    coord_t pos[AXES];
    logic   last;
  } vertex_t;

  typedef struct {
    coord_t                low[AXES];
    coord_t                high[AXES];
    coord_t                center[AXES];
    logic [DIAG_BITS-1:0]  diagonal;
    logic [SCALE_BITS-1:0] scale;
    logic                  degenerate;
  } box_result_t;

  typedef struct {
    vertex_t     v;
    bit          typed;
    box_result_t want;
  } stim_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write_en;
  logic [SPAN_BITS-1:0] cfg_write_data;

  bbn_vertex_if #(.COORD_BITS(COORD_BITS)) vtx ();
  bbn_result_if #(.COORD_BITS(COORD_BITS)) res ();

  bounding_box_normalizer #(.COORD_BITS(COORD_BITS)) i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .vertex         (vtx),
    .result         (res)
  );

  coord_t               box_min[AXES];
  coord_t               box_max[AXES];
  logic [SPAN_BITS-1:0] span;
  box_result_t          pending_boxes[$];
  int                   mismatch_count;
  int                   result_count;
  bit                   sender_eager;
  bit                   recv_eager;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic void clear_box();
    int a;
    for (a = 0; a < AXES; a++) begin
      box_min[a] = COORD_MAX;
      box_max[a] = COORD_MIN;
    end
  endfunction

  // folds one vertex into the running box, returns 1 with the box on the last one
  function automatic bit fold_vertex(input vertex_t v, output box_result_t box);
    u64_t                 sq_sum;
    u64_t                 quotient;
    int                   ext;
    int                   a;
    int                   b;
    logic [DIAG_BITS-1:0] root;
    logic [DIAG_BITS-1:0] cand;
    sq_sum = 0;
    root   = '0;
    for (a = 0; a < AXES; a++) begin
      if (v.pos[a] < box_min[a]) box_min[a] = v.pos[a];
      if (v.pos[a] > box_max[a]) box_max[a] = v.pos[a];
    end
    if (!v.last) return 1'b0;
    for (a = 0; a < AXES; a++) begin
      ext = int'(box_max[a]) - int'(box_min[a]);
      sq_sum += u64_t'(ext) * u64_t'(ext);
      box.low[a]    = box_min[a];
      box.high[a]   = box_max[a];
      box.center[a] = coord_t'((int'(box_min[a]) + int'(box_max[a])) >>> 1);
    end
    for (b = DIAG_BITS - 1; b >= 0; b--) begin
      cand = root | (DIAG_BITS'(1) << b);
      if (u64_t'(cand) * u64_t'(cand) <= sq_sum) root = cand;
    end
    box.diagonal = root;
    if (root == '0) begin
      box.scale      = SCALE_SAT;
      box.degenerate = 1'b1;
    end else begin
      quotient = (u64_t'(span) << SCALE_FRAC) / u64_t'(root);
      if (quotient > u64_t'(SCALE_SAT)) begin
        box.scale      = SCALE_SAT;
        box.degenerate = 1'b1;
      end else begin
        box.scale      = quotient[SCALE_BITS-1:0];
        box.degenerate = 1'b0;
      end
    end
    clear_box();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    $display("result %0d: %s is %0d, want %0d", result_count, what, got, want);
  endtask

  task automatic check_box(input box_result_t got);
    box_result_t want;
    string       axis_tag[AXES];
    int          a;
    axis_tag = '{"x", "y", "z"};
    if (pending_boxes.size() == 0) begin
      report_mismatch("unexpected transfer", 1, 0);
      return;
    end
    want = pending_boxes.pop_front();
    for (a = 0; a < AXES; a++) begin
      if (got.low[a] !== want.low[a])
        report_mismatch({"low_", axis_tag[a]}, got.low[a], want.low[a]);
      if (got.high[a] !== want.high[a])
        report_mismatch({"high_", axis_tag[a]}, got.high[a], want.high[a]);
      if (got.center[a] !== want.center[a])
        report_mismatch({"center_", axis_tag[a]}, got.center[a], want.center[a]);
    end
    if (got.diagonal !== want.diagonal)
      report_mismatch("diagonal", got.diagonal, want.diagonal);
    if (got.scale !== want.scale)
      report_mismatch("scale_factor", got.scale, want.scale);
    if (got.degenerate !== want.degenerate)
      report_mismatch("degenerate", got.degenerate, want.degenerate);
  endtask

  function automatic stim_row_t vtx_row(input int x, input int y, input int z, input bit last);
    stim_row_t row;
    row.v.pos[0] = coord_t'(x);
    row.v.pos[1] = coord_t'(y);
    row.v.pos[2] = coord_t'(z);
    row.v.last   = last;
    row.typed    = 1'b0;
    return row;
  endfunction

  // last vertex with its result typed in
  function automatic stim_row_t box_row(input int x, input int y, input int z,
                                        input int lx, input int ly, input int lz,
                                        input int hx, input int hy, input int hz,
                                        input int cx, input int cy, input int cz,
                                        input int dg, input u64_t sc, input bit dn);
    stim_row_t row;
    row = vtx_row(x, y, z, 1'b1);
    row.typed            = 1'b1;
    row.want.low         = '{coord_t'(lx), coord_t'(ly), coord_t'(lz)};
    row.want.high        = '{coord_t'(hx), coord_t'(hy), coord_t'(hz)};
    row.want.center      = '{coord_t'(cx), coord_t'(cy), coord_t'(cz)};
    row.want.diagonal    = DIAG_BITS'(dg);
    row.want.scale       = SCALE_BITS'(sc);
    row.want.degenerate  = dn;
    return row;
  endfunction

  function automatic int sender_gap();
    return sender_eager ? 0 : int'($urandom_range(0, 7));
  endfunction

  function automatic coord_t pick_coord(input spread_t spread, input coord_t base);
    case (spread)
      SPREAD_TIGHT: return base + coord_t'($urandom_range(0, 3));
      SPREAD_POINT: return base;
      SPREAD_EXTREME: begin
        case ($urandom_range(0, 4))
          0: return COORD_MIN;
          1: return COORD_MAX;
          2: return '0;
          3: return '1;
          default: return coord_t'($urandom);
        endcase
      end
      default: return coord_t'($urandom);
    endcase
  endfunction

  // called just after a falling edge, returns just after a falling edge
  task automatic drive_vertex(input vertex_t v, input bit typed, input box_result_t want,
                              input int gap);
    box_result_t box;
    if (gap > 0) begin
      vtx.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    vtx.valid       <= 1'b1;
    vtx.vertex_x    <= v.pos[0];
    vtx.vertex_y    <= v.pos[1];
    vtx.vertex_z    <= v.pos[2];
    vtx.last_vertex <= v.last;
    do @(posedge clk); while (!vtx.ready);
    if (fold_vertex(v, box)) pending_boxes.push_back(typed ? want : box);
    @(negedge clk);
  endtask

  task automatic idle_and_drain();
    vtx.valid <= 1'b0;
    while (pending_boxes.size() != 0) @(negedge clk);
    repeat (BUSY_CYCLES) @(negedge clk);
  endtask

  task automatic write_span(input logic [SPAN_BITS-1:0] value);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
    span = value;
  endtask

  // result side
  initial begin
    int          gap;
    box_result_t got;
    res.ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (result_count % 20 == 0) recv_eager = ($urandom_range(0, 3) == 0);
      gap = recv_eager ? 0 : int'($urandom_range(0, 7));
      if (result_count == 25 || result_count == 150) gap = HOLD_CYCLES;
      if (gap > 0) begin
        res.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!res.valid);
      got.low        = '{res.low_x, res.low_y, res.low_z};
      got.high       = '{res.high_x, res.high_y, res.high_z};
      got.center     = '{res.center_x, res.center_y, res.center_z};
      got.diagonal   = res.diagonal;
      got.scale      = res.scale_factor;
      got.degenerate = res.degenerate;
      check_box(got);
      result_count++;
      @(negedge clk);
    end
  end

  // vertex side
  initial begin
    stim_row_t            rows[$];
    box_result_t          no_box;
    vertex_t              v;
    coord_t               base[AXES];
    spread_t              spread;
    logic [SPAN_BITS-1:0] new_span;
    int                   items;
    int                   len;
    int                   pick;
    int                   phase;
    int                   k;
    int                   a;

    rst             = 1'b1;
    cfg_write_en    = 1'b0;
    cfg_write_data  = '0;
    vtx.valid       = 1'b0;
    vtx.vertex_x    = '0;
    vtx.vertex_y    = '0;
    vtx.vertex_z    = '0;
    vtx.last_vertex = 1'b0;
    span            = SPAN_RESET;
    mismatch_count  = 0;
    result_count    = 0;
    sender_eager    = 1'b0;
    recv_eager      = 1'b0;
    clear_box();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // single vertex at origin and at both corners of the range
    rows.push_back(box_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, SCALE_SAT, 1'b1));
    rows.push_back(box_row(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                           C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 0, SCALE_SAT, 1'b1));
    rows.push_back(box_row(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                           C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 0, SCALE_SAT, 1'b1));
    // widest box
    rows.push_back(vtx_row(C_MIN, C_MIN, C_MIN, 1'b0));
    rows.push_back(vtx_row(C_MAX, C_MAX, C_MAX, 1'b1));
    // diagonals of one, two and three units
    rows.push_back(vtx_row(0, 0, 0, 1'b0));
    rows.push_back(box_row(1, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1, SCALE_SAT, 1'b1));
    rows.push_back(vtx_row(0, 0, 0, 1'b0));
    rows.push_back(vtx_row(2, 0, 0, 1'b1));
    rows.push_back(vtx_row(0, 0, 0, 1'b0));
    rows.push_back(vtx_row(0, 3, 0, 1'b1));
    // odd negative sums for the centroid
    rows.push_back(vtx_row(-3, -1, -5, 1'b0));
    rows.push_back(vtx_row(0, 0, 0, 1'b0));
    rows.push_back(vtx_row(0, 0, 1, 1'b1));
    rows.push_back(vtx_row(C_MAX, C_MIN, 0, 1'b0));
    rows.push_back(vtx_row(C_MIN, C_MAX, -1, 1'b0));
    rows.push_back(vtx_row(5, -7, 65536, 1'b1));
    rows.push_back(box_row(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, 0, SCALE_SAT, 1'b1));
    rows.push_back(vtx_row(0, 0, C_MIN, 1'b0));
    rows.push_back(vtx_row(0, 0, C_MAX, 1'b1));
    rows.push_back(vtx_row(C_MIN, 0, 0, 1'b0));
    rows.push_back(vtx_row(C_MAX, 0, 0, 1'b1));

    foreach (rows[i]) drive_vertex(rows[i].v, rows[i].typed, rows[i].want, sender_gap());

    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      idle_and_drain();
      case (phase)
        0:       new_span = SPAN_BITS'(1);
        1:       new_span = SPAN_MAX;
        2:       new_span = SPAN_BITS'($urandom_range(1, 255));
        default: new_span = SPAN_BITS'($urandom_range(1, int'(SPAN_MAX)));
      endcase
      write_span(new_span);
      items = 0;
      while (items < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        len  = (pick < 80) ? $urandom_range(1, 8) : (pick < 95) ? $urandom_range(9, 40) : 1;
        pick = $urandom_range(0, 9);
        spread = (pick < 5) ? SPREAD_FULL : (pick < 7) ? SPREAD_TIGHT :
                 (pick < 9) ? SPREAD_EXTREME : SPREAD_POINT;
        sender_eager = ($urandom_range(0, 5) == 0);
        for (a = 0; a < AXES; a++) base[a] = coord_t'($urandom);
        for (k = 0; k < len; k++) begin
          for (a = 0; a < AXES; a++) v.pos[a] = pick_coord(spread, base[a]);
          v.last = (k == len - 1);
          drive_vertex(v, 1'b0, no_box, sender_gap());
        end
        items += len;
      end
      // loose vertices left in the box across the span change
      if (phase % 2 == 1) begin
        for (k = 0; k < 3; k++) begin
          for (a = 0; a < AXES; a++) v.pos[a] = coord_t'($urandom);
          v.last = 1'b0;
          drive_vertex(v, 1'b0, no_box, sender_gap());
        end
      end
    end

    idle_and_drain();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
